### hdl/modular_exponent_decrypt_core_macros.svh
// Assertion macros for the modular exponent decrypt core.
`ifndef MODULAR_EXPONENT_DECRYPT_CORE_MACROS_SVH
`define MODULAR_EXPONENT_DECRYPT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MEXP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MEXP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mexp_pkg.sv
// Shared constants and types of the modular exponent decrypt core.
`default_nettype none
package mexp_pkg;

    localparam int RES_W            = 31;
    localparam int CIPHER_W         = 64;
    localparam int BYTE_W           = 8;
    localparam int CFG_W            = 31;
    localparam int CFG_IDX_W        = 1;
    localparam int STEP_W           = 7;
    localparam int MUL_STEPS        = RES_W;
    localparam int RED_STEPS        = CIPHER_W;
    localparam int DEFAULT_EXP_BITS = 31;

    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MODULUS      = 1'b1;

    localparam logic [CFG_W-1:0] EXP_RESET = CFG_W'(1);
    localparam logic [CFG_W-1:0] MOD_RESET = CFG_W'(1);

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } mm_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_sts_t;

endpackage
`default_nettype wire

### hdl/mexp_ifs.sv
// Handshake channel interfaces for ciphertext input and plaintext output.
`default_nettype none
interface mexp_in_if;
    import mexp_pkg::*;

    logic                valid;
    logic                ready;
    logic [CIPHER_W-1:0] cipher_word;

    modport source (output valid, output cipher_word, input ready);
    modport sink   (input valid, input cipher_word, output ready);
endinterface

interface mexp_out_if;
    import mexp_pkg::*;

    logic              valid;
    logic              ready;
    logic [RES_W-1:0]  residue;
    logic [BYTE_W-1:0] plain_byte;

    modport source (output valid, output residue, output plain_byte, input ready);
    modport sink   (input valid, input residue, input plain_byte, output ready);
endinterface
`default_nettype wire

### hdl/modular_exponent_decrypt_core.sv
// A word with a zero exponent goes from the transfer straight to the finish state; otherwise
//   the word is reduced, then squared per exponent bit and also multiplied on a one bit.
// One word at a time; the next word transfers once the result is in the output register.
// Every modular product, the reduction of the word included, runs in the bit-serial multiplier.
// Reset: asynchronous, active low; exponent and modulus return to 1, the block idles.
`default_nettype none
`include "modular_exponent_decrypt_core_macros.svh"
module modular_exponent_decrypt_core #(
    parameter int EXP_BITS = mexp_pkg::DEFAULT_EXP_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mexp_in_if.sink                         cipher,
    mexp_out_if.source                      plain,
    input  logic                            cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mexp_pkg::CFG_W-1:0]      cfg_data
);
    import mexp_pkg::*;

    localparam int EXT_W = (EXP_BITS > CFG_W) ? EXP_BITS : CFG_W;
    localparam int CNT_W = $clog2(EXP_BITS + 1);
    localparam int PAD_W = CIPHER_W - RES_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_SQUARE = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_W-1:0] exp_cfg_reg;
    logic [CFG_W-1:0] mod_cfg_reg;

    // exponent scan, MSB first
    logic [EXP_BITS-1:0] exp_sh_reg;
    logic [CNT_W-1:0]    exp_cnt_reg;

    logic [RES_W-1:0] acc_reg;
    logic [RES_W-1:0] base_reg;
    logic [RES_W-1:0] res_out_reg;
    logic             out_valid_reg;

    logic [EXT_W-1:0]    exp_ext;
    logic [EXP_BITS-1:0] exp_eff;
    logic                exp_zero;
    logic [RES_W-1:0]    n_eff;
    logic                accept;
    logic                out_load;
    logic                last_bit;

    mm_ctl_t             mm_ctl;
    mm_sts_t             mm_sts;
    logic [RES_W-1:0]    mm_addend;
    logic [CIPHER_W-1:0] mm_mult;
    logic [RES_W-1:0]    mm_result;

    logic                in_compute;
    logic                word_begun;

    // Only the low EXP_BITS bits of the exponent count; bits above the register read as zero.
    assign exp_ext  = EXT_W'(exp_cfg_reg);
    assign exp_eff  = exp_ext[EXP_BITS-1:0];
    assign exp_zero = (exp_eff == '0);

    // A zero modulus acts as one.
    assign n_eff = (mod_cfg_reg == '0) ? RES_W'(1) : mod_cfg_reg[RES_W-1:0];

    assign cipher.ready = (state_reg == ST_IDLE);
    assign accept       = cipher.valid && cipher.ready;
    assign last_bit     = (exp_cnt_reg == CNT_W'(1));

    // Hand the result over once the output register is free or being drained.
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || plain.ready);

    // Sequencer: reduce, then square (and multiply on a one bit) per exponent bit, if nonzero.
    always_comb
    begin
        state_next   = state_reg;
        mm_ctl.start = 1'b0;
        mm_ctl.steps = STEP_W'(MUL_STEPS);
        mm_addend    = mm_result;
        mm_mult      = {mm_result, {PAD_W{1'b0}}};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (exp_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // c mod n: shift the word in, adding one per set bit
                        mm_ctl.start = 1'b1;
                        mm_ctl.steps = STEP_W'(RED_STEPS);
                        mm_addend    = RES_W'(1);
                        mm_mult      = cipher.cipher_word;
                        state_next   = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mm_sts.done)
                begin
                    mm_ctl.start = 1'b1;
                    mm_addend    = acc_reg;
                    mm_mult      = {acc_reg, {PAD_W{1'b0}}};
                    state_next   = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (mm_sts.done)
                begin
                    if (exp_sh_reg[EXP_BITS-1])
                    begin
                        mm_ctl.start = 1'b1;
                        mm_addend    = base_reg;
                        state_next   = ST_MULT;
                    end
                    else if (last_bit)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mm_ctl.start = 1'b1;
                    end
                end
            end
            ST_MULT:
            begin
                if (mm_sts.done)
                begin
                    if (last_bit)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mm_ctl.start = 1'b1;
                        state_next   = ST_SQUARE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    mexp_mulmod u_mulmod (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mm_ctl),
        .addend     (mm_addend),
        .multiplier (mm_mult),
        .modulus    (n_eff),
        .sts        (mm_sts),
        .result     (mm_result)
    );

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            exp_cfg_reg   <= EXP_RESET;
            mod_cfg_reg   <= MOD_RESET;
            exp_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PRIVATE_EXPONENT: exp_cfg_reg <= cfg_data;
                    REG_KEY_MODULUS:      mod_cfg_reg <= cfg_data;
                    default:              ;
                endcase
            end

            // Advance the bit count after the last product of each exponent bit.
            if (accept)
            begin
                exp_cnt_reg <= CNT_W'(EXP_BITS);
            end
            else if (mm_sts.done && ((state_reg == ST_MULT) ||
                     ((state_reg == ST_SQUARE) && !exp_sh_reg[EXP_BITS-1])))
            begin
                exp_cnt_reg <= exp_cnt_reg - CNT_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (plain.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            exp_sh_reg <= exp_eff;
            // Zero exponent gives 1 unreduced; otherwise start from 1 mod n.
            if (exp_zero || (n_eff != RES_W'(1)))
            begin
                acc_reg <= RES_W'(1);
            end
            else
            begin
                acc_reg <= '0;
            end
        end
        else if (mm_sts.done)
        begin
            case (state_reg)
                ST_REDUCE:
                begin
                    base_reg <= mm_result;
                end
                ST_SQUARE:
                begin
                    acc_reg <= mm_result;
                    if (!exp_sh_reg[EXP_BITS-1])
                    begin
                        exp_sh_reg <= exp_sh_reg << 1;
                    end
                end
                ST_MULT:
                begin
                    acc_reg    <= mm_result;
                    exp_sh_reg <= exp_sh_reg << 1;
                end
                default:
                begin
                end
            endcase
        end

        if (out_load)
        begin
            res_out_reg <= acc_reg;
        end
    end

    assign plain.valid      = out_valid_reg;
    assign plain.residue    = res_out_reg;
    assign plain.plain_byte = res_out_reg[BYTE_W-1:0];

    // State decode for the checks below.
    assign in_compute = state_reg inside {ST_REDUCE, ST_SQUARE, ST_MULT};
    assign word_begun = state_reg inside {ST_REDUCE, ST_FINISH};

    `MEXP_ASSERT(a_mm_start_free, mm_ctl.start |-> !mm_sts.busy, "multiplier started while busy")
    `MEXP_ASSERT(a_mm_done_in_compute, mm_sts.done |-> in_compute, "stray multiplier done")
    `MEXP_ASSERT_NEXT(a_accept_leaves_idle, accept, word_begun, "transfer did not start a word")
    `MEXP_ASSERT(a_base_reduced, (state_reg == ST_MULT) |-> (base_reg < n_eff), "unreduced base")

endmodule
`default_nettype wire

### hdl/mexp_mulmod.sv
// Bit-serial modular multiply-accumulate unit: one multiplier bit per cycle.
`default_nettype none
module mexp_mulmod (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mexp_pkg::mm_ctl_t              ctl,
    input  logic [mexp_pkg::RES_W-1:0]     addend,
    input  logic [mexp_pkg::CIPHER_W-1:0]  multiplier,
    input  logic [mexp_pkg::RES_W-1:0]     modulus,
    output mexp_pkg::mm_sts_t              sts,
    output logic [mexp_pkg::RES_W-1:0]     result
);
    import mexp_pkg::*;

    localparam int SUM_W = RES_W + 2;

    logic [RES_W-1:0]    acc_reg,  acc_next;
    logic [RES_W-1:0]    add_reg;
    logic [CIPHER_W-1:0] sh_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] n1;
    logic [SUM_W-1:0] n2;
    logic [SUM_W-1:0] red;

    // acc = 2*acc + bit*addend, then bring back below the modulus
    always_comb
    begin
        n1  = {2'b00, modulus};
        n2  = {1'b0, modulus, 1'b0};
        sum = {1'b0, acc_reg, 1'b0}
              + (sh_reg[CIPHER_W-1] ? {2'b00, add_reg} : {SUM_W{1'b0}});
        if (sum >= n2)
        begin
            red = sum - n2;
        end
        else if (sum >= n1)
        begin
            red = sum - n1;
        end
        else
        begin
            red = sum;
        end
        acc_next = red[RES_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg <= '0;
            add_reg <= addend;
            sh_reg  <= multiplier;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            sh_reg  <= {sh_reg[CIPHER_W-2:0], 1'b0};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = acc_reg;

endmodule
`default_nettype wire
